// ===== src/tpcf_pkg.sv =====
// Package for the transparent pixel color fill block.
// Holds store geometry, operation codes and the sequencer state type.
// No dependencies.
package tpcf_pkg;

    localparam int MAX_WIDTH  = 64;
    localparam int MAX_HEIGHT = 64;
    localparam int XW         = 6;
    localparam int YW         = 6;
    localparam int SW         = 7;
    localparam int DEPTH      = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW         = $clog2(DEPTH);
    localparam int SUMW       = 12;
    localparam int ACCW       = 20;
    localparam int QW         = 8;

    typedef logic [1:0] t_op;
    localparam t_op OP_LOAD = 2'd0;
    localparam t_op OP_RUN  = 2'd1;
    localparam t_op OP_READ = 2'd2;

    typedef logic [1:0] t_cfg_idx;
    localparam t_cfg_idx CFG_THRESHOLD = 2'd0;
    localparam t_cfg_idx CFG_WIDTH     = 2'd1;
    localparam t_cfg_idx CFG_HEIGHT    = 2'd2;

    typedef enum logic [10:0] {
        S_IDLE   = 11'b000_0000_0001,
        S_RDPIX  = 11'b000_0000_0010,
        S_MARK_R = 11'b000_0000_0100,
        S_MARK_W = 11'b000_0000_1000,
        S_CTR_R  = 11'b000_0001_0000,
        S_CTR_C  = 11'b000_0010_0000,
        S_NB_R   = 11'b000_0100_0000,
        S_NB_A   = 11'b000_1000_0000,
        S_DIV    = 11'b001_0000_0000,
        S_WRITE  = 11'b010_0000_0000,
        S_DONE   = 11'b100_0000_0000
    } t_state;

    function automatic logic [SW-1:0] clamp_size(input logic [SW-1:0] v,
                                                 input logic [SW-1:0] maxv);
        logic [SW-1:0] r;
        r = v;
        if (v == '0) r = SW'(1);
        else if (v > maxv) r = maxv;
        return r;
    endfunction

endpackage

// ===== src/tpcf_pix_if.sv =====
// Input channel of the transparent pixel color fill block.
// Depends on tpcf_pkg.
interface tpcf_pix_if;
    import tpcf_pkg::*;
    logic              valid;
    logic              ready;
    logic [1:0]        operation;
    logic [XW-1:0]     pixel_x;
    logic [YW-1:0]     pixel_y;
    logic [7:0]        red_in;
    logic [7:0]        green_in;
    logic [7:0]        blue_in;
    logic [7:0]        alpha_in;
    modport source (output valid, operation, pixel_x, pixel_y, red_in, green_in,
                    blue_in, alpha_in, input ready);
    modport sink   (input valid, operation, pixel_x, pixel_y, red_in, green_in,
                    blue_in, alpha_in, output ready);
endinterface

// ===== src/tpcf_res_if.sv =====
// Result channel of the transparent pixel color fill block.
// No dependencies.
interface tpcf_res_if;
    logic       valid;
    logic       ready;
    logic [7:0] red_out;
    logic [7:0] green_out;
    logic [7:0] blue_out;
    logic [7:0] alpha_out;
    logic       fill_done;
    modport source (output valid, red_out, green_out, blue_out, alpha_out, fill_done,
                    input ready);
    modport sink   (input valid, red_out, green_out, blue_out, alpha_out, fill_done,
                    output ready);
endinterface

// ===== src/tpcf_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module tpcf_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

// ===== src/tpcf_div.sv =====
// Restoring divider, one quotient bit per cycle, QW quotient bits per division.
// Depends on tpcf_pkg.
module tpcf_div
    import tpcf_pkg::*;
(
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_start,
    input  logic [ACCW-1:0] i_dividend,
    input  logic [SUMW-1:0] i_divisor,
    output logic            o_busy,
    output logic [QW-1:0]   o_quot
);
    logic [ACCW-1:0]       r_rem;
    logic [SUMW-1:0]       r_dvs;
    logic [$clog2(QW)-1:0] r_cnt;
    logic                  r_busy;
    logic [QW-1:0]         r_q;
    logic [ACCW-1:0]       trial;

    assign trial = ACCW'(r_dvs) << r_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (i_start) begin
            r_busy <= 1'b1;
        end else if (r_busy && r_cnt == '0) begin
            r_busy <= 1'b0;
        end
        if (i_start) begin
            r_rem <= i_dividend;
            r_dvs <= i_divisor;
            r_cnt <= $clog2(QW)'(QW - 1);
            r_q   <= '0;
        end else if (r_busy) begin
            if (r_rem >= trial) begin
                r_rem        <= r_rem - trial;
                r_q[r_cnt]   <= 1'b1;
            end
            r_cnt <= r_cnt - 1'b1;
        end
    end

    assign o_busy = r_busy;
    assign o_quot = r_q;
endmodule

// ===== src/transparent_pixel_color_fill.sv =====
// Transparent pixel color fill: top level with pixel store, done marks and sequencer.
// Depends on tpcf_pkg, tpcf_pix_if, tpcf_res_if, tpcf_ram, tpcf_div.
//
// Usage: items arrive on i_pix (valid/ready) and each gives one result on o_res.
// A load writes one pixel into the 64x64 store and answers zeros. A read answers the
// stored RGBA, taken from the registered read port into the output register. A run
// recolors each transparent pixel that has a done neighbor from those neighbors and
// answers fill_done = 1 when it has finished. A run first marks every pixel of the
// image as done or open, then per pass reads each pixel, skips a done one, and for
// an open pixel makes nine neighbor reads on the single read port of each memory,
// runs the bit-serial divider and, if any neighbor was done, writes the pixel back.
// Passes = max(2, 11 - max(W,H)/16). Configuration is a plain write port (threshold,
// width, height); the user must write it only while idle, which the block does not
// enforce. Reset (synchronous, active low) clears the sequencer and output valid flag
// and sets threshold 0, size 64x64; the store is undefined until loaded.
// When the receiver stalls the result is held in the output register and new items
// are taken only once it has been transferred or is being transferred.
module transparent_pixel_color_fill
    import tpcf_pkg::*;
(
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_cfg_we,
    input  t_cfg_idx       i_cfg_idx,
    input  logic [7:0]     i_cfg_data,
    tpcf_pix_if.sink       i_pix,
    tpcf_res_if.source     o_res
);
    t_state          r_state, n_state;
    logic [7:0]      r_thr;
    logic [SW-1:0]   r_wreg, r_hreg, r_w, r_h;
    logic [XW-1:0]   r_x;
    logic [YW-1:0]   r_y;
    logic [3:0]      r_pass, r_passes;
    logic [1:0]      r_nx, r_ny;
    logic [SUMW-1:0] r_ss, n_ss;
    logic [ACCW-1:0] r_sr, r_sg, r_sb, n_sr, n_sg, n_sb;
    logic [7:0]      r_alpha;
    logic            r_ov, r_fd;
    logic [31:0]     r_od;

    logic            take, last_px, last_nb, nb_ok, div_start;
    logic            qb_busy, qg_busy, qr_busy;
    logic [QW-1:0]   q_r, q_g, q_b;
    logic [AW-1:0]   idx, nb_addr, item_addr, raddr;
    logic [7:0]      sy_t, sx_t;
    logic            pix_we, dn_we, dn_wdata, dn_rdata;
    logic [AW-1:0]   pix_waddr;
    logic [31:0]     pix_wdata, pix_rdata;
    logic [7:0]      wgt;
    logic [SW-1:0]   mx, w_c, h_c;
    logic signed [7:0] pt;

    assign take      = i_pix.valid && i_pix.ready;
    assign i_pix.ready = (r_state == S_IDLE) && (!r_ov || o_res.ready);
    assign item_addr = AW'(32'(i_pix.pixel_y) * MAX_WIDTH + 32'(i_pix.pixel_x));
    assign idx       = AW'(32'(r_y) * MAX_WIDTH + 32'(r_x));
    assign sy_t      = 8'(r_y) + 8'(r_ny);
    assign sx_t      = 8'(r_x) + 8'(r_nx);
    assign nb_ok     = (sy_t != '0) && (sy_t <= 8'(r_h)) && (sx_t != '0) && (sx_t <= 8'(r_w));
    assign nb_addr   = AW'(32'(YW'(sy_t - 8'd1)) * MAX_WIDTH + 32'(XW'(sx_t - 8'd1)));
    assign last_px   = ({1'b0, r_x} == r_w - 1'b1) && ({1'b0, r_y} == r_h - 1'b1);
    assign last_nb   = (r_nx == 2'd2) && (r_ny == 2'd2);
    assign wgt       = (pix_rdata[31:24] <= r_thr) ? 8'd255 : pix_rdata[31:24];
    assign w_c       = clamp_size(r_wreg, SW'(MAX_WIDTH));
    assign h_c       = clamp_size(r_hreg, SW'(MAX_HEIGHT));
    assign mx        = (w_c > h_c) ? w_c : h_c;
    assign pt        = 8'sd11 - signed'(8'(mx >> 4));
    assign div_start = (r_state == S_NB_A) && last_nb;

    always_comb begin
        n_ss = r_ss;
        n_sr = r_sr;
        n_sg = r_sg;
        n_sb = r_sb;
        if (nb_ok && dn_rdata) begin
            n_ss = r_ss + SUMW'(wgt);
            n_sr = r_sr + ACCW'(16'(wgt) * 16'(pix_rdata[7:0]));
            n_sg = r_sg + ACCW'(16'(wgt) * 16'(pix_rdata[15:8]));
            n_sb = r_sb + ACCW'(16'(wgt) * 16'(pix_rdata[23:16]));
        end
    end

    always_comb begin
        unique case (r_state)
            S_IDLE:                raddr = item_addr;
            S_NB_R:                raddr = nb_addr;
            default:               raddr = idx;
        endcase
    end

    always_comb begin
        pix_we    = 1'b0;
        pix_waddr = idx;
        pix_wdata = {r_alpha, q_b, q_g, q_r};
        dn_we     = 1'b0;
        dn_wdata  = 1'b1;
        if (r_state == S_IDLE && take && i_pix.operation == OP_LOAD &&
            32'(i_pix.pixel_x) < MAX_WIDTH && 32'(i_pix.pixel_y) < MAX_HEIGHT) begin
            pix_we    = 1'b1;
            pix_waddr = item_addr;
            pix_wdata = {i_pix.alpha_in, i_pix.blue_in, i_pix.green_in, i_pix.red_in};
        end else if (r_state == S_WRITE) begin
            pix_we = 1'b1;
            dn_we  = 1'b1;
        end else if (r_state == S_MARK_W) begin
            dn_we    = 1'b1;
            dn_wdata = pix_rdata[31:24] > r_thr;
        end
    end

    tpcf_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_pix (
        .i_clk(i_clk), .i_we(pix_we), .i_waddr(pix_waddr), .i_wdata(pix_wdata),
        .i_raddr(raddr), .o_rdata(pix_rdata)
    );

    tpcf_ram #(.WIDTH(1), .DEPTH(DEPTH)) u_done (
        .i_clk(i_clk), .i_we(dn_we), .i_waddr(idx), .i_wdata(dn_wdata),
        .i_raddr(raddr), .o_rdata(dn_rdata)
    );

    tpcf_div u_div_r (.i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(div_start),
        .i_dividend(n_sr), .i_divisor(n_ss), .o_busy(qr_busy), .o_quot(q_r));
    tpcf_div u_div_g (.i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(div_start),
        .i_dividend(n_sg), .i_divisor(n_ss), .o_busy(qg_busy), .o_quot(q_g));
    tpcf_div u_div_b (.i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(div_start),
        .i_dividend(n_sb), .i_divisor(n_ss), .o_busy(qb_busy), .o_quot(q_b));

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (take && i_pix.operation == OP_READ) n_state = S_RDPIX;
                else if (take && i_pix.operation == OP_RUN) n_state = S_MARK_R;
            end
            S_RDPIX:  n_state = S_IDLE;
            S_MARK_R: n_state = S_MARK_W;
            S_MARK_W: n_state = last_px ? S_CTR_R : S_MARK_R;
            S_CTR_R:  n_state = S_CTR_C;
            S_CTR_C: begin
                if (!dn_rdata) n_state = S_NB_R;
                else if (last_px && r_pass == r_passes - 1'b1) n_state = S_DONE;
                else n_state = S_CTR_R;
            end
            S_NB_R:   n_state = S_NB_A;
            S_NB_A: begin
                if (!last_nb) n_state = S_NB_R;
                else n_state = S_DIV;
            end
            S_DIV: begin
                if (!qr_busy && r_ss == '0) begin
                    n_state = (last_px && r_pass == r_passes - 1'b1) ? S_DONE : S_CTR_R;
                end else if (!qr_busy) begin
                    n_state = S_WRITE;
                end
            end
            S_WRITE:  n_state = (last_px && r_pass == r_passes - 1'b1) ? S_DONE : S_CTR_R;
            S_DONE:   n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_thr   <= '0;
            r_wreg  <= SW'(64);
            r_hreg  <= SW'(64);
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_THRESHOLD: r_thr  <= i_cfg_data;
                    CFG_WIDTH:     r_wreg <= i_cfg_data[SW-1:0];
                    CFG_HEIGHT:    r_hreg <= i_cfg_data[SW-1:0];
                    default:       ;
                endcase
            end
            if ((r_state == S_IDLE && take && i_pix.operation != OP_READ &&
                 i_pix.operation != OP_RUN) || r_state == S_RDPIX || r_state == S_DONE) begin
                r_ov <= 1'b1;
            end else if (o_res.ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && take) begin
            r_od <= '0;
            r_fd <= 1'b0;
            r_x  <= '0;
            r_y  <= '0;
            r_pass <= '0;
            r_w  <= w_c;
            r_h  <= h_c;
            r_passes <= (pt < 8'sd2) ? 4'd2 : 4'(pt);
        end
        if (r_state == S_RDPIX) r_od <= pix_rdata;
        if (r_state == S_DONE)  r_fd <= 1'b1;
        if (r_state == S_CTR_C) begin
            r_alpha <= pix_rdata[31:24];
            r_ss <= '0; r_sr <= '0; r_sg <= '0; r_sb <= '0;
            r_nx <= '0; r_ny <= '0;
        end
        if (r_state == S_NB_A) begin
            r_ss <= n_ss;
            r_sr <= n_sr;
            r_sg <= n_sg;
            r_sb <= n_sb;
            if (r_nx == 2'd2) begin
                r_nx <= '0;
                r_ny <= r_ny + 1'b1;
            end else begin
                r_nx <= r_nx + 1'b1;
            end
        end
        if (r_state == S_MARK_W || (r_state == S_CTR_C && dn_rdata) || r_state == S_WRITE ||
            (r_state == S_DIV && !qr_busy && r_ss == '0)) begin
            if ({1'b0, r_x} == r_w - 1'b1) begin
                r_x <= '0;
                if ({1'b0, r_y} == r_h - 1'b1) begin
                    r_y <= '0;
                    if (r_state != S_MARK_W) r_pass <= r_pass + 1'b1;
                end else begin
                    r_y <= r_y + 1'b1;
                end
            end else begin
                r_x <= r_x + 1'b1;
            end
        end
    end

    assign o_res.valid     = r_ov;
    assign o_res.red_out   = r_od[7:0];
    assign o_res.green_out = r_od[15:8];
    assign o_res.blue_out  = r_od[23:16];
    assign o_res.alpha_out = r_od[31:24];
    assign o_res.fill_done = r_fd;

    a_div_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WRITE) |-> (r_ss != '0))
        else $error("pixel written back with no done neighbor");
    a_div_lockstep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (qr_busy == qg_busy) && (qr_busy == qb_busy))
        else $error("channel dividers out of step");
    a_run_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (take && i_pix.operation == OP_RUN) |=> (r_state == S_MARK_R))
        else $error("run item did not start the mark sweep");
    a_store_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pix_we |-> (r_state == S_IDLE || r_state == S_WRITE))
        else $error("pixel store written outside load or write-back");
endmodule
